[sv/dits_pkg.sv]
// Shared types and codes for the display init table sequencer.
`timescale 1ns / 1ps

package dits_pkg;

  localparam logic [1:0] KIND_WORD      = 2'd0;
  localparam logic [1:0] KIND_FRAME_END = 2'd1;
  localparam logic [1:0] KIND_WAIT      = 2'd2;

  localparam logic [6:0] COUNT_MASK = 7'h7F;
  localparam int         DELAY_BIT  = 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    PH_CMD   = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_DELAY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       dc;
    logic [7:0] value;
    logic       end_follows;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[sv/dits_front.sv]
// Front end: parses table bytes into send jobs.
`timescale 1ns / 1ps

module dits_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               accept,
  input  logic [7:0]         table_byte,
  input  logic               table_end,
  output logic               push,
  output dits_pkg::job_t     job
);

  dits_pkg::phase_t phase;
  dits_pkg::phase_t phase_next;
  logic [7:0] held_command;
  logic [6:0] bytes_left;
  logic [6:0] bytes_left_next;
  logic       delay_follows;
  logic       delay_follows_next;
  logic       push_raw;
  logic [6:0] dec_left;

  assign dec_left = bytes_left - 7'd1;

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    delay_follows_next = delay_follows;
    push_raw           = 1'b0;
    job                = '0;
    case (phase)
      dits_pkg::PH_CMD: begin
        phase_next = table_end ? dits_pkg::PH_CMD : dits_pkg::PH_LEN;
      end
      dits_pkg::PH_LEN: begin
        push_raw           = 1'b1;
        job.kind           = dits_pkg::KIND_WORD;
        job.dc             = 1'b0;
        job.value          = held_command;
        bytes_left_next    = table_byte[6:0] & dits_pkg::COUNT_MASK;
        delay_follows_next = table_byte[dits_pkg::DELAY_BIT];
        if (bytes_left_next == 7'd0) begin
          job.end_follows = 1'b1;
          phase_next = (delay_follows_next && !table_end) ? dits_pkg::PH_DELAY
                                                          : dits_pkg::PH_CMD;
        end else if (table_end) begin
          job.end_follows = 1'b1;
          phase_next      = dits_pkg::PH_CMD;
        end else begin
          phase_next = dits_pkg::PH_DATA;
        end
      end
      dits_pkg::PH_DATA: begin
        push_raw        = 1'b1;
        job.kind        = dits_pkg::KIND_WORD;
        job.dc          = 1'b1;
        job.value       = table_byte;
        bytes_left_next = dec_left;
        if (dec_left == 7'd0) begin
          job.end_follows = 1'b1;
          phase_next = (delay_follows && !table_end) ? dits_pkg::PH_DELAY
                                                     : dits_pkg::PH_CMD;
        end else if (table_end) begin
          job.end_follows = 1'b1;
          phase_next      = dits_pkg::PH_CMD;
        end
      end
      dits_pkg::PH_DELAY: begin
        push_raw   = (table_byte != 8'd0);
        job.kind   = dits_pkg::KIND_WAIT;
        job.value  = table_byte;
        phase_next = dits_pkg::PH_CMD;
      end
      default: begin
        phase_next = dits_pkg::PH_CMD;
      end
    endcase
  end

  assign push = accept && push_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dits_pkg::PH_CMD;
      bytes_left    <= 7'd0;
      delay_follows <= 1'b0;
      held_command  <= 8'd0;
    end else if (accept) begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      delay_follows <= delay_follows_next;
      if (phase == dits_pkg::PH_CMD) begin
        held_command <= table_byte;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |-> in_valid)
    else $error("front: accept without valid");
`endif

endmodule

[sv/dits_queue.sv]
// Short job queue between the parser and the output sequencer.
`timescale 1ns / 1ps

module dits_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dits_pkg::job_t          push_job,
  input  logic                    pop,
  output dits_pkg::job_t          head,
  output dits_pkg::queue_status_t status
);

  dits_pkg::job_t entries [dits_pkg::QUEUE_DEPTH];
  logic [dits_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [dits_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [dits_pkg::QUEUE_AW:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign status.full  = (count == (dits_pkg::QUEUE_AW + 1)'(dits_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/dits_back.sv]
// Back end: expands queued jobs into output transactions.
`timescale 1ns / 1ps

module dits_back (
  input  logic                    clk,
  input  logic                    rst,
  input  dits_pkg::job_t          head,
  input  dits_pkg::queue_status_t status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              kind,
  output logic                    dc,
  output logic [7:0]              value,
  output logic                    last
);

  logic pend_end;
  logic load;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !pend_end && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_end  <= 1'b0;
    end else if (load) begin
      if (pend_end) begin
        out_valid <= 1'b1;
        pend_end  <= 1'b0;
      end else if (!status.empty) begin
        out_valid <= 1'b1;
        pend_end  <= head.end_follows;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_end) begin
        kind  <= dits_pkg::KIND_FRAME_END;
        dc    <= 1'b0;
        value <= 8'd0;
        last  <= 1'b1;
      end else begin
        kind  <= head.kind;
        dc    <= head.dc;
        value <= head.value;
        last  <= !head.end_follows;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == dits_pkg::KIND_FRAME_END || kind == dits_pkg::KIND_WAIT))
      |-> last)
    else $error("back: frame end or wait not marked last");
  a_pend_needs_word: assert property (@(posedge clk) disable iff (rst)
    pend_end |-> (out_valid && kind == dits_pkg::KIND_WORD && !last))
    else $error("back: pending frame end without a leading word");
  a_no_pop_when_pending: assert property (@(posedge clk) disable iff (rst)
    pend_end |-> !pop)
    else $error("back: job taken while frame end pending");
`endif

endmodule

[sv/display_init_table_sequencer.sv]
// Top level of the display init table sequencer.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+---------------------------------
//   input    | in_valid  | in_stall  | table_byte, table_end
//   output   | out_valid | out_stall | kind, dc, value, last
//
// A byte is taken every cycle while the two-entry job queue has room.
// Each byte yields at most two transactions, one per cycle at the output
// while out_stall is low, so the output port sets the sustained byte rate.
// out_valid rises once a job has passed the queue and the output register.
// rst is synchronous; it clears the parser phase, the queue and the output stage.
// Output stall backs up the queue, which then raises in_stall.
`timescale 1ns / 1ps

module display_init_table_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] table_byte,
  input  logic       table_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic       dc,
  output logic [7:0] value,
  output logic       last
);

  dits_pkg::job_t          push_job;
  dits_pkg::job_t          head;
  dits_pkg::queue_status_t status;
  logic                    push;
  logic                    pop;
  logic                    accept;

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  dits_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .accept     (accept),
    .table_byte (table_byte),
    .table_end  (table_end),
    .push       (push),
    .job        (push_job)
  );

  dits_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  dits_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .dc        (dc),
    .value     (value),
    .last      (last)
  );

endmodule

[dv/dits_checker.sv]
// Checker for the display init table sequencer: predicts and compares output transactions.
`timescale 1ns / 1ps

module dits_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] table_byte,
  input  logic       table_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] kind,
  input  logic       dc,
  input  logic [7:0] value,
  input  logic       last,
  output int         fail_count,
  output int         ops_outstanding
);

  typedef struct packed {
    logic [1:0] kind;
    logic       dc;
    logic [7:0] value;
    logic       last;
  } lcd_op_t;

  lcd_op_t ops_due[$];
  int      mismatches = 0;

  dits_pkg::phase_t parse_phase;
  logic [7:0]       held_cmd;
  logic [6:0]       data_left;
  logic             delay_pending;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic lcd_op_t make_op(input logic [1:0] k, input logic d, input logic [7:0] v);
    lcd_op_t op;
    op.kind  = k;
    op.dc    = d;
    op.value = v;
    op.last  = 1'b0;
    return op;
  endfunction

  task automatic parse_table_byte(input logic [7:0] b, input logic tail);
    lcd_op_t ops[$];
    case (parse_phase)
      dits_pkg::PH_CMD: begin
        held_cmd    = b;
        parse_phase = tail ? dits_pkg::PH_CMD : dits_pkg::PH_LEN;
      end
      dits_pkg::PH_LEN: begin
        ops.push_back(make_op(dits_pkg::KIND_WORD, 1'b0, held_cmd));
        data_left     = b[6:0] & dits_pkg::COUNT_MASK;
        delay_pending = b[dits_pkg::DELAY_BIT];
        if (data_left == 7'd0) begin
          ops.push_back(make_op(dits_pkg::KIND_FRAME_END, 1'b0, 8'd0));
          parse_phase = (delay_pending && !tail) ? dits_pkg::PH_DELAY : dits_pkg::PH_CMD;
        end else if (tail) begin
          ops.push_back(make_op(dits_pkg::KIND_FRAME_END, 1'b0, 8'd0));
          parse_phase = dits_pkg::PH_CMD;
        end else begin
          parse_phase = dits_pkg::PH_DATA;
        end
      end
      dits_pkg::PH_DATA: begin
        ops.push_back(make_op(dits_pkg::KIND_WORD, 1'b1, b));
        data_left = data_left - 7'd1;
        if (data_left == 7'd0) begin
          ops.push_back(make_op(dits_pkg::KIND_FRAME_END, 1'b0, 8'd0));
          parse_phase = (delay_pending && !tail) ? dits_pkg::PH_DELAY : dits_pkg::PH_CMD;
        end else if (tail) begin
          ops.push_back(make_op(dits_pkg::KIND_FRAME_END, 1'b0, 8'd0));
          parse_phase = dits_pkg::PH_CMD;
        end
      end
      default: begin
        if (b != 8'd0) ops.push_back(make_op(dits_pkg::KIND_WAIT, 1'b0, b));
        parse_phase = dits_pkg::PH_CMD;
      end
    endcase
    if (ops.size() > 0) ops[ops.size() - 1].last = 1'b1;
    foreach (ops[i]) ops_due.push_back(ops[i]);
  endtask

  always @(posedge clk) begin
    lcd_op_t want;
    if (rst) begin
      ops_due.delete();
      parse_phase   = dits_pkg::PH_CMD;
      held_cmd      = 8'd0;
      data_left     = 7'd0;
      delay_pending = 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_table_byte(table_byte, table_end);
      if (out_valid && !out_stall) begin
        if (ops_due.size() == 0) begin
          report($sformatf("unexpected transaction kind=%0d dc=%0d value=%02h last=%0d",
                           kind, dc, value, last));
        end else begin
          want = ops_due.pop_front();
          if (kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (dc !== want.dc)
            report($sformatf("dc %0d, expected %0d (kind %0d)", dc, want.dc, want.kind));
          if (value !== want.value)
            report($sformatf("value %02h, expected %02h (kind %0d)", value, want.value,
                             want.kind));
          if (last !== want.last)
            report($sformatf("last %0d, expected %0d (kind %0d)", last, want.last,
                             want.kind));
        end
      end
    end
    ops_outstanding <= ops_due.size();
    fail_count      <= mismatches;
  end

endmodule

[dv/testbench.sv]
// Testbench top for the display init table sequencer: clock, reset, table stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [7:0] data;
    logic       tail;
  } table_entry_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic [7:0] table_byte = 8'd0;
  logic       table_end  = 1'b0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] kind;
  logic       dc;
  logic [7:0] value;
  logic       last;
  int         fail_count;
  int         ops_outstanding;

  int           send_gap_pct = 0;
  int           stall_pct    = 0;
  int           bytes_sent   = 0;
  table_entry_t table_bytes[$];

  display_init_table_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .table_byte(table_byte),
    .table_end (table_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .dc        (dc),
    .value     (value),
    .last      (last)
  );

  dits_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .table_byte     (table_byte),
    .table_end      (table_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .dc             (dc),
    .value          (value),
    .last           (last),
    .fail_count     (fail_count),
    .ops_outstanding(ops_outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic tail);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    table_byte <= b;
    table_end  <= tail;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic tail);
    table_entry_t ent;
    ent.data = b;
    ent.tail = tail;
    table_bytes.push_back(ent);
  endtask

  task automatic send_table();
    foreach (table_bytes[i]) send_byte(table_bytes[i].data, table_bytes[i].tail);
    table_bytes.delete();
  endtask

  // one record with random content; rarely the longest data count
  task automatic add_record();
    int   count;
    logic with_delay;
    count      = ($urandom_range(99) < 2) ? 127 : $urandom_range(6);
    with_delay = 1'($urandom_range(1));
    push_byte(8'($urandom_range(255)), 1'b0);
    push_byte({with_delay, 7'(count)}, 1'b0);
    for (int i = 0; i < count; i++) push_byte(8'($urandom_range(255)), 1'b0);
    if (with_delay) push_byte(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic build_table();
    int nrec;
    nrec = $urandom_range(1, 3);
    for (int r = 0; r < nrec; r++) add_record();
    table_bytes[table_bytes.size() - 1].tail = 1'b1;
  endtask

  task automatic random_traffic(input int nbytes);
    int start;
    int pick;
    int cut;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        build_table();
      end else if (pick < 90) begin
        // truncate a well-formed table
        build_table();
        if (table_bytes.size() > 1) begin
          cut = $urandom_range(1, table_bytes.size() - 1);
          while (table_bytes.size() > cut) void'(table_bytes.pop_back());
        end
        table_bytes[table_bytes.size() - 1].tail = 1'b1;
      end else begin
        repeat ($urandom_range(1, 8))
          push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        if ($urandom_range(1)) table_bytes[table_bytes.size() - 1].tail = 1'b1;
      end
      send_table();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero data count, no delay
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    // max values with delay
    push_byte(8'hFF, 1'b0); push_byte(8'h81, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    // zero count with delay, zero delay
    push_byte(8'h5A, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);
    // lone command byte
    push_byte(8'hA5, 1'b1);
    // record cut short with pending delay
    push_byte(8'h11, 1'b0); push_byte(8'h83, 1'b0); push_byte(8'h22, 1'b1);
    // table ends on the length byte
    push_byte(8'h33, 1'b0); push_byte(8'h02, 1'b1);
    // delay flag when the frame closes at table end
    push_byte(8'h44, 1'b0); push_byte(8'h81, 1'b0); push_byte(8'h55, 1'b1);
    push_byte(8'h66, 1'b0); push_byte(8'h80, 1'b1);
    // delay byte flagged as table end
    push_byte(8'h77, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b1);
    send_table();

    send_gap_pct = 0;  stall_pct = 0;  random_traffic(240);
    send_gap_pct = 53; stall_pct = 0;  random_traffic(240);
    send_gap_pct = 0;  stall_pct = 53; random_traffic(240);
    send_gap_pct = 12; stall_pct = 12; random_traffic(240);

    in_valid <= 1'b0;
    @(posedge clk);
    while (ops_outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && ops_outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
